// ===== sv/fdecho_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdecho_pkg
// Register map and fixed field widths of the feedback delay echo.
// ----------------------------------------------------------------------------
package fdecho_pkg;

   localparam int LENGTH_BITS = 17;
   localparam int GAIN_BITS   = 16;
   localparam int CSR_BITS    = 17;
   localparam int INDEX_BITS  = 2;

   typedef logic [INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_DELAY_LENGTH = 2'd0;
   localparam csr_index_type CSR_MIX_GAIN     = 2'd1;
   localparam csr_index_type CSR_REGEN_GAIN   = 2'd2;

   localparam logic [LENGTH_BITS-1:0] DELAY_LENGTH_RESET = 17'd1;

endpackage
`default_nettype wire

// ===== sv/fdecho_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdecho_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdecho_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/feedback_delay_echo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_delay_echo
// Feedback comb filter: out = x + mix*d, stored = x + feedback*d, saturated.
// ----------------------------------------------------------------------------
// Usage
//   Samples enter on the req_ channel and results leave on the rsp_ channel,
//   both valid/ready. Every item gives exactly one result, in order.
//   Registers are written through csr_write_enable/csr_index/csr_write_data
//   while the block is idle: 0 delay length, 1 mix gain, 2 feedback gain.
//   An accepted sample is computed in the next cycle in the compute stage,
//   and its result is then registered into the output queue, from which it
//   is offered on the rsp_ channel.
//   Throughput: one item per cycle while req_ready is high. The delay line is
//   read when the item is accepted and written back in the cycle after; a read
//   of the word still being written is served from a forwarding register.
//   Reset clears the position and a fill count, so words not yet written
//   read as zero; no clearing pass runs and items are taken right after
//   reset. When the receiver stalls, up to three results wait in an output
//   queue and req_ready drops once the queue and the compute stage together
//   hold three items.
// ----------------------------------------------------------------------------
module feedback_delay_echo #(
   parameter int MAX_LENGTH  = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_in_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]              rsp_out_sample,
   input  wire logic                                  csr_write_enable,
   input  wire logic [fdecho_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [fdecho_pkg::CSR_BITS-1:0]       csr_write_data
);

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int CW = (AW + 1 > fdecho_pkg::LENGTH_BITS) ? AW + 1 : fdecho_pkg::LENGTH_BITS;
   localparam int SB = SAMPLE_BITS;
   localparam int GB = fdecho_pkg::GAIN_BITS;
   localparam int PW = SB + GB + 1;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_LENGTH);

   // Configuration registers.
   logic [fdecho_pkg::LENGTH_BITS-1:0] delay_length_ff;
   logic [GB-1:0]                      mix_gain_ff, regen_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff <= fdecho_pkg::DELAY_LENGTH_RESET;
         mix_gain_ff     <= '0;
         regen_gain_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            fdecho_pkg::CSR_DELAY_LENGTH: delay_length_ff <= csr_write_data;
            fdecho_pkg::CSR_MIX_GAIN:     mix_gain_ff     <= csr_write_data[GB-1:0];
            fdecho_pkg::CSR_REGEN_GAIN:   regen_gain_ff   <= csr_write_data[GB-1:0];
            default: ;
         endcase
      end
   end

   // Position and fill count. Written words always form the range below the
   // fill count, since the position only steps by one or returns to zero.
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [CW-1:0] len_eff, next_pos;
   logic          accept, filled;

   assign accept = req_valid && req_ready;

   always_comb begin
      len_eff = CW'(delay_length_ff);
      if (len_eff == '0) begin
         len_eff = CW'(1);
      end
      if (len_eff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end
      next_pos = CW'(pos_ff) + CW'(1);
      filled   = {1'b0, pos_ff} < fill_ff;
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      if (accept) begin
         pos_in = (next_pos >= len_eff) ? '0 : next_pos[AW-1:0];
         if ({1'b0, pos_ff} == fill_ff) begin
            fill_in = fill_ff + (AW+1)'(1);
         end
      end
   end

   // Compute stage and forwarding register of the last write.
   logic                 s1_valid_ff, s1_filled_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic signed [SB-1:0] s1_sample_ff;
   logic                 last_valid_ff;
   logic [AW-1:0]        last_addr_ff;
   logic signed [SB-1:0] last_word_ff;
   logic [SB-1:0]        ram_q;
   logic signed [SB-1:0] echo, out_word, store_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         fill_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         fill_ff       <= fill_in;
         s1_valid_ff   <= accept;
         last_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff   <= pos_ff;
      s1_filled_ff <= filled;
      s1_sample_ff <= req_in_sample;
      last_addr_ff <= s1_addr_ff;
      last_word_ff <= store_word;
   end

   function automatic logic signed [SB-1:0] saturate(input logic signed [SB+1:0] v);
      logic signed [SB-1:0] r;
      begin
         if (v[SB+1:SB-1] == 3'b000 || v[SB+1:SB-1] == 3'b111) begin
            r = v[SB-1:0];
         end else if (v[SB+1]) begin
            r = {1'b1, {(SB-1){1'b0}}};
         end else begin
            r = {1'b0, {(SB-1){1'b1}}};
         end
         saturate = r;
      end
   endfunction

   logic signed [PW-1:0] mix_prod, fb_prod;
   logic signed [SB+1:0] x_ext, mix_sum, fb_sum;

   always_comb begin
      if (last_valid_ff && last_addr_ff == s1_addr_ff) begin
         echo = last_word_ff;
      end else if (s1_filled_ff) begin
         echo = $signed(ram_q);
      end else begin
         echo = '0;
      end
      mix_prod   = echo * $signed({1'b0, mix_gain_ff});
      fb_prod    = echo * $signed({1'b0, regen_gain_ff});
      x_ext      = {{2{s1_sample_ff[SB-1]}}, s1_sample_ff};
      mix_sum    = x_ext + $signed(mix_prod[PW-1:15]);
      fb_sum     = x_ext + $signed(fb_prod[PW-1:15]);
      out_word   = saturate(mix_sum);
      store_word = saturate(fb_sum);
   end

   fdecho_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_LENGTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (store_word),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ram_q)
   );

   // Output queue of three items.
   logic signed [SB-1:0] queue_ff [3];
   logic [1:0]           wr_ptr_ff, rd_ptr_ff, count_ff;
   logic                 pop;

   assign rsp_valid      = count_ff != 2'd0;
   assign rsp_out_sample = queue_ff[rd_ptr_ff];
   assign pop            = rsp_valid && rsp_ready;
   assign req_ready      = ({1'b0, count_ff} + {2'b00, s1_valid_ff}) < 3'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == 2'd2) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == 2'd2) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {1'b0, s1_valid_ff} - {1'b0, pop};
      end
      if (s1_valid_ff) begin
         queue_ff[wr_ptr_ff] <= out_word;
      end
   end

   // The compute stage never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) s1_valid_ff |-> count_ff != 2'd3)
      else $error("output queue overflow");

   // Every accepted item reaches the compute stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> s1_valid_ff)
      else $error("accepted item lost before compute stage");

   // The position never runs past the written range.
   assert property (@(posedge clock) disable iff (reset) {1'b0, pos_ff} <= fill_ff)
      else $error("position beyond fill count");

   // The fill count only grows by one on an accepted item.
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fill_ff))
      else $error("fill count changed without an item");

endmodule
`default_nettype wire
